/* rtl/dpwt_pkg.sv */
// shared types and constants for the duplicate packet window table
package dpwt_pkg;

    localparam int SERIAL_W = 16;
    localparam int NUMBER_W = 8;
    localparam int WINDOW_W = 8;
    localparam int SLOT_W   = 5;
    localparam int ENTRY_W  = SERIAL_W + NUMBER_W;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 8'd8;

    localparam logic KIND_CHECK  = 1'b0;
    localparam logic KIND_RECORD = 1'b1;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic decide;
        logic out_load;
    } dpwt_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } dpwt_status_t;

endpackage

/* rtl/dpwt_ram.sv */
// generic single-port-write ram with registered read
module dpwt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 31
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/dpwt_ctrl.sv */
// controller state machine for the table scan
module dpwt_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  dpwt_pkg::dpwt_status_t status,
    output dpwt_pkg::dpwt_cmd_t    cmd
);

    import dpwt_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_DECIDE = 5'b01000,
        ST_RESULT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/dpwt_datapath.sv */
// table storage, scan compare, window check and result registers
module dpwt_datapath #(
    parameter int SLOTS = 31
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dpwt_pkg::dpwt_cmd_t               cmd,
    output dpwt_pkg::dpwt_status_t            status,
    input  logic                              cfg_wr_en,
    input  logic [dpwt_pkg::WINDOW_W-1:0]     cfg_wr_data,
    input  logic                              kind,
    input  logic [dpwt_pkg::SERIAL_W-1:0]     source_serial,
    input  logic [dpwt_pkg::NUMBER_W-1:0]     packet_number,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              accepted,
    output logic [dpwt_pkg::SLOT_W-1:0]       slot_used,
    output logic                              table_cleared
);

    import dpwt_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST_ADDR = IW'(SLOTS - 1);

    logic [WINDOW_W-1:0] window_reg;
    logic                kind_reg;
    logic [SERIAL_W-1:0] serial_reg;
    logic [NUMBER_W-1:0] number_reg;
    logic [IW-1:0]       addr_reg;
    logic                cmp_valid_reg;
    logic [IW-1:0]       cmp_idx_reg;
    logic [SLOTS-1:0]    valid_reg;
    logic [SLOTS-1:0]    valid_next;
    logic                found_reg;
    logic [IW-1:0]       found_idx_reg;
    logic [NUMBER_W-1:0] found_num_reg;
    logic                free_reg;
    logic [IW-1:0]       free_idx_reg;
    logic                res_accept_reg;
    logic [SLOT_W-1:0]   res_slot_reg;
    logic                res_clear_reg;
    logic                out_valid_reg;
    logic                accepted_reg;
    logic [SLOT_W-1:0]   slot_used_reg;
    logic                table_cleared_reg;

    logic [ENTRY_W-1:0]  rdata;
    logic [SERIAL_W-1:0] entry_serial;
    logic [NUMBER_W-1:0] entry_number;
    logic                hit_match;
    logic                hit_free;

    logic signed [NUMBER_W+1:0] now_val;
    logic signed [NUMBER_W+1:0] past_val;
    logic signed [NUMBER_W+1:0] low_val;
    logic                       do_accept;
    logic                       do_clear;
    logic [IW-1:0]              wr_idx;
    logic [IW+SLOT_W-1:0]       slot_ext;
    logic                       ram_we;

    dpwt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_idx),
        .wdata ({serial_reg, number_reg}),
        .re    (cmd.rd_en),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    // entry that was never written or was wiped reads as free
    assign entry_serial = valid_reg[cmp_idx_reg] ? rdata[ENTRY_W-1:NUMBER_W] : '0;
    assign entry_number = valid_reg[cmp_idx_reg] ? rdata[NUMBER_W-1:0] : '0;
    assign hit_match    = cmp_valid_reg && !found_reg && (entry_serial == serial_reg);
    assign hit_free     = cmp_valid_reg && !free_reg && (entry_serial == '0);

    assign now_val   = signed'({2'b00, number_reg});
    assign past_val  = signed'({2'b00, found_num_reg});
    assign low_val   = past_val - signed'({2'b00, window_reg});
    assign do_accept = (kind_reg == KIND_RECORD) || !found_reg
                       || (now_val > past_val) || (now_val < low_val);
    assign do_clear  = do_accept && !found_reg && !free_reg;
    assign wr_idx    = found_reg ? found_idx_reg : (free_reg ? free_idx_reg : '0);
    assign slot_ext  = {{SLOT_W{1'b0}}, wr_idx};
    assign ram_we    = cmd.decide && do_accept;

    always_comb
    begin
        valid_next = valid_reg;
        if (ram_we)
        begin
            if (do_clear)
            begin
                valid_next = SLOTS'(1);
            end
            else
            begin
                valid_next = valid_reg | (SLOTS'(1) << wr_idx);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= WINDOW_RESET;
            addr_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            valid_reg     <= '0;
            found_reg     <= 1'b0;
            free_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                window_reg <= cfg_wr_data;
            end
            cmp_valid_reg <= cmd.rd_en;
            if (cmd.load)
            begin
                addr_reg  <= '0;
                found_reg <= 1'b0;
                free_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.rd_en)
                begin
                    addr_reg <= addr_reg + IW'(1);
                end
                if (hit_match)
                begin
                    found_reg <= 1'b1;
                end
                if (hit_free)
                begin
                    free_reg <= 1'b1;
                end
            end
            valid_reg <= valid_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg   <= kind;
            serial_reg <= source_serial;
            number_reg <= packet_number;
        end
        cmp_idx_reg <= addr_reg;
        if (hit_match)
        begin
            found_idx_reg <= cmp_idx_reg;
            found_num_reg <= entry_number;
        end
        if (hit_free)
        begin
            free_idx_reg <= cmp_idx_reg;
        end
        if (cmd.decide)
        begin
            res_accept_reg <= do_accept;
            res_slot_reg   <= do_accept ? slot_ext[SLOT_W-1:0] : '0;
            res_clear_reg  <= do_clear;
        end
        if (cmd.out_load)
        begin
            accepted_reg      <= res_accept_reg;
            slot_used_reg     <= res_slot_reg;
            table_cleared_reg <= res_clear_reg;
        end
    end

    assign status.scan_last = (addr_reg == LAST_ADDR);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign accepted      = accepted_reg;
    assign slot_used     = slot_used_reg;
    assign table_cleared = table_cleared_reg;

endmodule

/* rtl/duplicate_packet_window_table_top.sv */
// top level of the duplicate packet window table
//
// input channel in_valid/in_ready carries one transaction per packet: kind
// (check a received packet or record an own sent number), source_serial and
// packet_number. output channel out_valid/out_ready returns one transaction
// per input: accepted, slot_used and table_cleared.
// cfg_wr_en/cfg_wr_data write window_count; the user must do so only while
// idle, the block itself does not enforce this. each input is handled by a
// sequential scan of the slot ram, one slot a cycle, and no further input is
// taken until the scan and decision for the current one are done; the scan
// over the single read port of the slot ram is what limits the throughput.
// the result sits in an output register; the next input is taken while it
// waits. if the receiver stalls, a second finished result waits in the
// datapath and no further input is taken until the first one leaves.
// reset clears all slot valid bits at once, so the table reads as empty
// right away, and window_count returns to 8.
module duplicate_packet_window_table_top #(
    parameter int SLOTS = 31
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [dpwt_pkg::WINDOW_W-1:0] cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic [dpwt_pkg::SERIAL_W-1:0] source_serial,
    input  logic [dpwt_pkg::NUMBER_W-1:0] packet_number,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          accepted,
    output logic [dpwt_pkg::SLOT_W-1:0]   slot_used,
    output logic                          table_cleared
);

    import dpwt_pkg::*;

    dpwt_cmd_t    cmd;
    dpwt_status_t status;

    dpwt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    dpwt_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .kind          (kind),
        .source_serial (source_serial),
        .packet_number (packet_number),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .accepted      (accepted),
        .slot_used     (slot_used),
        .table_cleared (table_cleared)
    );

    a_cleared_implies_slot0: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_cleared |-> accepted && (slot_used == '0))
        else $error("wiped table without accepting into slot 0");

    a_reject_writes_nothing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> (slot_used == '0) && !table_cleared)
        else $error("rejected packet reports a write");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction taken during scan");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result overwrote a waiting output");

endmodule
